// ----- rtl/core/wcd_pkg.sv -----
package wcd_pkg;

    // Payload counter and held length width
    localparam int COUNT_BITS = 24;

    localparam int MAX_PAYLOAD_BITS = 24;
    localparam logic [MAX_PAYLOAD_BITS-1:0] MAX_PAYLOAD_RST = MAX_PAYLOAD_BITS'(1024 * 1024);

    // Compare width for length against the limit
    localparam int CMP_BITS = (COUNT_BITS > MAX_PAYLOAD_BITS) ? COUNT_BITS : MAX_PAYLOAD_BITS;

    localparam logic [3:0] PREFIX_LEN      = 4'd12;
    localparam logic [3:0] ALT_VERSION_POS = 4'd7;

    localparam logic [7:0] CHR_CR   = 8'h0d;
    localparam logic [7:0] CHR_LF   = 8'h0a;
    localparam logic [7:0] CHR_ZERO = 8'h30;

    localparam logic [3:0] OPCODE_MASK = 4'hf;
    localparam logic [6:0] LEN_EXT16   = 7'd126;
    localparam logic [6:0] LEN_EXT64   = 7'd127;
    localparam logic [3:0] EXT16_BYTES = 4'd2;
    localparam logic [3:0] EXT64_BYTES = 4'd8;
    localparam logic [3:0] KEY_BYTES   = 4'd4;

    typedef enum logic [2:0] {
        PH_HS   = 3'd0,
        PH_H0   = 3'd1,
        PH_H1   = 3'd2,
        PH_EXT  = 3'd3,
        PH_KEY  = 3'd4,
        PH_DATA = 3'd5,
        PH_DEAD = 3'd6
    } phase_t;

    typedef enum logic [2:0] {
        EV_DATA    = 3'd0,
        EV_EMPTY   = 3'd1,
        EV_HS_OK   = 3'd2,
        EV_HS_REJ  = 3'd3,
        EV_TOO_BIG = 3'd4
    } event_t;

    typedef struct packed {
        logic       mode;
        logic [7:0] rx_byte;
    } in_beat_t;

    typedef struct packed {
        logic [2:0] event_res;
        logic [3:0] frame_opcode;
        logic [7:0] payload_byte;
        logic       last_of_frame;
    } out_beat_t;

    // "HTTP/1.1 101"
    function automatic logic [7:0] prefix_char(input logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = 8'h48;
            4'd1:    c = 8'h54;
            4'd2:    c = 8'h54;
            4'd3:    c = 8'h50;
            4'd4:    c = 8'h2f;
            4'd5:    c = 8'h31;
            4'd6:    c = 8'h2e;
            4'd7:    c = 8'h31;
            4'd8:    c = 8'h20;
            4'd9:    c = 8'h31;
            4'd10:   c = 8'h30;
            4'd11:   c = 8'h31;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // CR LF CR LF
    function automatic logic [7:0] term_char(input logic [1:0] idx);
        return idx[0] ? CHR_LF : CHR_CR;
    endfunction

endpackage

// ----- rtl/core/websocket_client_deframer.sv -----
// WebSocket client receive deframer. Takes one received byte per beat on s_*, first
// scanning the HTTP upgrade reply up to CRLFCRLF (accepted only if it opens with
// "HTTP/1.1 101" or "HTTP/1.0 101"), then parsing frame headers (opcode, mask bit,
// 7/16/64-bit length, optional mask key) and emitting each unmasked payload byte on
// m_* with the final byte of a frame flagged. A reply reject or a length above
// cfg max_payload (or the 2^COUNT_BITS-1 counter range) gives one error beat, after
// which bytes are dropped until a restart beat (mode = 1). Rate: one byte per clock
// while m_ready holds; each byte passes the input register, one pass of parse
// logic and the result register. s_ready follows m_ready combinationally when
// both registers are full; that single parse pass is what sets the cycle time.
module websocket_client_deframer (
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_valid,
    output logic                 s_ready,
    input  wcd_pkg::in_beat_t    s_data,

    output logic                 m_valid,
    input  logic                 m_ready,
    output wcd_pkg::out_beat_t   m_data,

    input  logic                 cfg_wr_en,
    input  logic [wcd_pkg::MAX_PAYLOAD_BITS-1:0] cfg_wr_data
);

    localparam int CB = wcd_pkg::COUNT_BITS;

    // ---------------------------------------------------------------------------
    // Handshake registers
    // ---------------------------------------------------------------------------
    logic                 in_valid_reg, in_valid_next;
    wcd_pkg::in_beat_t    in_data_reg;
    logic                 m_valid_reg, m_valid_next;
    wcd_pkg::out_beat_t   m_data_reg, m_data_next;

    logic                 out_free;
    logic                 advance;   // input register beat is consumed this cycle

    assign out_free = !m_valid_reg || m_ready;
    assign advance  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    // ---------------------------------------------------------------------------
    // Parse state
    // ---------------------------------------------------------------------------
    logic [wcd_pkg::MAX_PAYLOAD_BITS-1:0] max_payload_reg;

    wcd_pkg::phase_t phase_reg, phase_next;
    logic            prefix_ok_reg, prefix_ok_next;
    logic [3:0]      reply_cnt_reg, reply_cnt_next;
    logic [1:0]      term_prog_reg, term_prog_next;
    logic [3:0]      opcode_reg, opcode_next;
    logic            mask_on_reg, mask_on_next;
    logic [CB-1:0]   len_reg, len_next;
    // Sticky: some length bit above the counter range is set
    logic            len_over_reg, len_over_next;
    logic [3:0]      field_cnt_reg, field_cnt_next;
    logic [31:0]     mask_reg, mask_next;
    logic [CB-1:0]   pos_reg, pos_next;

    logic               res_valid;
    wcd_pkg::out_beat_t res;

    // Helper terms
    logic [7:0]    b;
    logic          prefix_hit;
    logic          len_end;     // length field complete this beat
    logic          pay_start;   // header and key complete this beat
    logic          too_big;
    logic [CB-1:0] pos_inc;
    logic          pay_last;
    logic [7:0]    key_byte;

    assign b        = in_data_reg.rx_byte;
    assign prefix_hit = (b == wcd_pkg::prefix_char(reply_cnt_reg)) ||
                        ((reply_cnt_reg == wcd_pkg::ALT_VERSION_POS) && (b == wcd_pkg::CHR_ZERO));
    assign pos_inc  = pos_reg + CB'(1);
    assign pay_last = (pos_inc >= len_reg);
    // Key byte for this payload position: byte 0 is the first key byte received
    assign key_byte = 8'(mask_reg >> {~pos_reg[1:0], 3'b000});
    assign too_big  = len_over_next ||
                      (wcd_pkg::CMP_BITS'(len_next) > wcd_pkg::CMP_BITS'(max_payload_reg));

    always_comb begin
        phase_next     = phase_reg;
        prefix_ok_next = prefix_ok_reg;
        reply_cnt_next = reply_cnt_reg;
        term_prog_next = term_prog_reg;
        opcode_next    = opcode_reg;
        mask_on_next   = mask_on_reg;
        len_next       = len_reg;
        len_over_next  = len_over_reg;
        field_cnt_next = field_cnt_reg;
        mask_next      = mask_reg;
        pos_next       = pos_reg;
        res_valid      = 1'b0;
        res            = '0;
        len_end        = 1'b0;
        pay_start      = 1'b0;

        if (advance) begin
            if (in_data_reg.mode) begin
                // Restart: back to reset parse state, limit register kept
                phase_next     = wcd_pkg::PH_HS;
                prefix_ok_next = 1'b1;
                reply_cnt_next = '0;
                term_prog_next = '0;
                opcode_next    = '0;
                mask_on_next   = 1'b0;
                len_next       = '0;
                len_over_next  = 1'b0;
                field_cnt_next = '0;
                mask_next      = '0;
                pos_next       = '0;
            end else begin
                case (phase_reg)
                    wcd_pkg::PH_HS: begin
                        if (reply_cnt_reg < wcd_pkg::PREFIX_LEN) begin
                            if (!prefix_hit) begin
                                prefix_ok_next = 1'b0;
                            end
                            reply_cnt_next = reply_cnt_reg + 4'd1;
                        end
                        if (b == wcd_pkg::term_char(term_prog_reg)) begin
                            if (term_prog_reg == 2'd3) begin
                                term_prog_next = '0;
                                res_valid      = 1'b1;
                                // Prefix check uses state before this byte; terminator
                                // can't be inside the prefix and still pass
                                if (prefix_ok_reg && (reply_cnt_reg >= wcd_pkg::PREFIX_LEN)) begin
                                    phase_next    = wcd_pkg::PH_H0;
                                    res.event_res = wcd_pkg::EV_HS_OK;
                                end else begin
                                    phase_next    = wcd_pkg::PH_DEAD;
                                    res.event_res = wcd_pkg::EV_HS_REJ;
                                end
                            end else begin
                                term_prog_next = term_prog_reg + 2'd1;
                            end
                        end else begin
                            term_prog_next = (b == wcd_pkg::CHR_CR) ? 2'd1 : 2'd0;
                        end
                    end
                    wcd_pkg::PH_H0: begin
                        opcode_next = b[3:0] & wcd_pkg::OPCODE_MASK;
                        phase_next  = wcd_pkg::PH_H1;
                    end
                    wcd_pkg::PH_H1: begin
                        mask_on_next  = b[7];
                        mask_next     = '0;
                        len_next      = '0;
                        len_over_next = 1'b0;
                        if (b[6:0] == wcd_pkg::LEN_EXT16) begin
                            field_cnt_next = wcd_pkg::EXT16_BYTES;
                            phase_next     = wcd_pkg::PH_EXT;
                        end else if (b[6:0] == wcd_pkg::LEN_EXT64) begin
                            field_cnt_next = wcd_pkg::EXT64_BYTES;
                            phase_next     = wcd_pkg::PH_EXT;
                        end else begin
                            len_next = CB'(b[6:0]);
                            len_end  = 1'b1;
                        end
                    end
                    wcd_pkg::PH_EXT: begin
                        len_over_next  = len_over_reg || (len_reg[CB-1 -: 8] != 8'd0);
                        len_next       = CB'({len_reg, b});
                        field_cnt_next = field_cnt_reg - 4'd1;
                        if (field_cnt_reg == 4'd1) begin
                            len_end = 1'b1;
                        end
                    end
                    wcd_pkg::PH_KEY: begin
                        mask_next      = {mask_reg[23:0], b};
                        field_cnt_next = field_cnt_reg - 4'd1;
                        if (field_cnt_reg == 4'd1) begin
                            pay_start = 1'b1;
                        end
                    end
                    wcd_pkg::PH_DATA: begin
                        res_valid         = 1'b1;
                        res.event_res     = wcd_pkg::EV_DATA;
                        res.frame_opcode  = opcode_reg;
                        res.payload_byte  = mask_on_reg ? (b ^ key_byte) : b;
                        res.last_of_frame = pay_last;
                        if (pay_last) begin
                            phase_next = wcd_pkg::PH_H0;
                            pos_next   = '0;
                        end else begin
                            pos_next = pos_inc;
                        end
                    end
                    default: begin
                        // Aborted: drop bytes until restart
                    end
                endcase

                if (len_end) begin
                    if (too_big) begin
                        phase_next       = wcd_pkg::PH_DEAD;
                        res_valid        = 1'b1;
                        res.event_res    = wcd_pkg::EV_TOO_BIG;
                        res.frame_opcode = opcode_reg;
                    end else if (mask_on_next) begin
                        phase_next     = wcd_pkg::PH_KEY;
                        field_cnt_next = wcd_pkg::KEY_BYTES;
                    end else begin
                        pay_start = 1'b1;
                    end
                end

                if (pay_start) begin
                    pos_next = '0;
                    if (len_next == '0) begin
                        phase_next        = wcd_pkg::PH_H0;
                        res_valid         = 1'b1;
                        res.event_res     = wcd_pkg::EV_EMPTY;
                        res.frame_opcode  = opcode_reg;
                        res.last_of_frame = 1'b1;
                    end else begin
                        phase_next = wcd_pkg::PH_DATA;
                    end
                end
            end
        end
    end

    // Handshake next values
    always_comb begin
        in_valid_next = (s_valid && s_ready) || (in_valid_reg && !advance);
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;
        if (out_free) begin
            m_valid_next = advance && res_valid;
            m_data_next  = res;
        end
    end

    // ---------------------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            m_valid_reg     <= 1'b0;
            max_payload_reg <= wcd_pkg::MAX_PAYLOAD_RST;
            phase_reg       <= wcd_pkg::PH_HS;
            prefix_ok_reg   <= 1'b1;
            reply_cnt_reg   <= '0;
            term_prog_reg   <= '0;
            opcode_reg      <= '0;
            mask_on_reg     <= 1'b0;
            len_reg         <= '0;
            len_over_reg    <= 1'b0;
            field_cnt_reg   <= '0;
            mask_reg        <= '0;
            pos_reg         <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            m_valid_reg   <= m_valid_next;
            if (cfg_wr_en) begin
                max_payload_reg <= cfg_wr_data;
            end
            phase_reg     <= phase_next;
            prefix_ok_reg <= prefix_ok_next;
            reply_cnt_reg <= reply_cnt_next;
            term_prog_reg <= term_prog_next;
            opcode_reg    <= opcode_next;
            mask_on_reg   <= mask_on_next;
            len_reg       <= len_next;
            len_over_reg  <= len_over_next;
            field_cnt_reg <= field_cnt_next;
            mask_reg      <= mask_next;
            pos_reg       <= pos_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        m_data_reg <= m_data_next;
    end

    // ---------------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------------
    // Once aborted, nothing comes out until a restart beat
    a_dead_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && (phase_reg == wcd_pkg::PH_DEAD)) |-> !res_valid)
        else $error("result produced while aborted");

    // Handshake verdicts only from reply scanning
    a_hs_from_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && res_valid && ((res.event_res == wcd_pkg::EV_HS_OK) ||
                                  (res.event_res == wcd_pkg::EV_HS_REJ)))
        |-> (phase_reg == wcd_pkg::PH_HS))
        else $error("handshake event outside reply scan");

    // In payload the position stays below an in-range, nonzero length
    a_data_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == wcd_pkg::PH_DATA) |-> ((pos_reg < len_reg) && !len_over_reg))
        else $error("payload position out of range");

    // Length and key fields always have bytes left to take
    a_field_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        ((phase_reg == wcd_pkg::PH_EXT) || (phase_reg == wcd_pkg::PH_KEY))
        |-> (field_cnt_reg != 4'd0))
        else $error("field byte count exhausted");

    // A consumed beat with a result lands in the output register
    a_res_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && res_valid) |=> m_valid_reg)
        else $error("result lost");

endmodule
